[sv/tcpc_pkg.sv]
`timescale 1ns / 1ps
package tcpc_pkg;

  typedef logic [15:0] cell_t;

  // request kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0f;

  localparam cell_t RESET_BLANK = {RESET_ATTR, SPACE_CHAR};

endpackage

[sv/tcpc_cell_ram.sv]
`timescale 1ns / 1ps
module tcpc_cell_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tcpc_pkg::cell_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tcpc_pkg::cell_t     rdata_o
);
  import tcpc_pkg::*;

  cell_t mem_q [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data out in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/text_console_put_char.sv]
`timescale 1ns / 1ps
// Text console engine: a COLUMNS x ROWS screen of 16-bit cells (attribute in the high
// byte, character in the low byte) held in one synchronous cell RAM, plus a cursor.
// A request is a put (newline moves to the start of the next row, any other byte is
// written at the cursor, which advances), a clear, or a read of one cell; every request
// gives one result with the cursor after it. One request is worked on at a time and
// the cost is set by the single RAM port pair: a read waits on the registered RAM
// read, a clear writes one cell per cycle, and a put that passes the last cell
// scrolls, copying COLUMNS*(ROWS-1) cells through a read/write-back pipeline and
// blanking the bottom row. After reset a clearing pass over all COLUMNS*ROWS cells
// fills the RAM with blanks before the first request is taken; attribute writes are
// taken at any time. A finished result sits in an output register, so the next
// request may be accepted while it waits.
module text_console_put_char #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // attribute register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  character_i,
  input  logic [10:0] cell_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cursor_position_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);
  import tcpc_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned CurW      = AddrW + 1;
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned CopyLen   = CellCount - COLUMNS;

  localparam logic [AddrW-1:0] LastCell = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] CopyEnd  = AddrW'(CopyLen);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(COLUMNS);
  localparam logic [ColW-1:0]  LastCol  = ColW'(COLUMNS - 1);
  localparam logic [CurW-1:0]  CurCells = CurW'(CellCount);
  localparam logic [CurW-1:0]  CurCols  = CurW'(COLUMNS);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] cursor_q, cursor_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [7:0]       attr_q;
  logic             rd_valid_q, rd_valid_d;
  logic [AddrW-1:0] wr_addr_q, wr_addr_d;
  logic             in_range_q, in_range_d;
  cell_t            pend_value_q, pend_value_d;
  logic             pend_scroll_q, pend_scroll_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_cursor_q, out_cursor_d;
  cell_t            out_value_q, out_value_d;
  logic             out_scroll_q, out_scroll_d;

  // cell RAM port signals
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  cell_t            ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  cell_t            ram_rdata;

  logic             accept;
  logic             is_newline;
  logic [CurW-1:0]  cur_adv;
  logic [ColW-1:0]  col_adv;
  logic             wrap;
  logic [31:0]      index_wide;
  logic [AddrW-1:0] read_addr;
  logic             read_ok;
  cell_t            blank;
  logic [31:0]      cursor_wide;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign is_newline = (character_i == NEWLINE_CHAR);
  assign blank      = {attr_q, SPACE_CHAR};

  // read index, range checked before the truncation to the RAM address
  assign index_wide = 32'(cell_index_i);
  assign read_addr  = index_wide[AddrW-1:0];
  assign read_ok    = (index_wide < CellCount);

  // cursor advance: row and column kept side by side, so newline needs no divide
  always_comb begin
    if (is_newline) begin
      cur_adv = {1'b0, cursor_q} + CurCols - CurW'(col_q);
      col_adv = '0;
    end else begin
      cur_adv = {1'b0, cursor_q} + CurW'(1);
      col_adv = (col_q == LastCol) ? '0 : col_q + ColW'(1);
    end
  end

  assign wrap = (cur_adv >= CurCells);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cursor_d      = cursor_q;
    col_d         = col_q;
    rd_valid_d    = 1'b0;
    wr_addr_d     = wr_addr_q;
    in_range_d    = in_range_q;
    pend_value_d  = pend_value_q;
    pend_scroll_d = pend_scroll_q;
    out_valid_d   = out_valid_q;
    out_cursor_d  = out_cursor_q;
    out_value_d   = out_value_q;
    out_scroll_d  = out_scroll_q;
    ram_we        = 1'b0;
    ram_waddr     = cnt_q;
    ram_wdata     = blank;
    ram_raddr     = cnt_q + RowStep;

    // result taken by the far side
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        // clearing pass after reset, always with the reset attribute
        ram_we    = 1'b1;
        ram_wdata = RESET_BLANK;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      S_IDLE: begin
        ram_raddr = read_addr;
        if (accept) begin
          pend_value_d  = '0;
          pend_scroll_d = 1'b0;
          unique case (kind_i)
            KIND_PUT: begin
              if (!is_newline) begin
                ram_we    = 1'b1;
                ram_waddr = cursor_q;
                ram_wdata = {attr_q, character_i};
              end
              col_d = col_adv;
              if (wrap) begin
                // back one row; the column is unchanged by that
                cursor_d      = AddrW'(cur_adv - CurCols);
                pend_scroll_d = 1'b1;
                cnt_d         = '0;
                state_d       = S_COPY;
              end else begin
                cursor_d = cur_adv[AddrW-1:0];
                state_d  = S_DONE;
              end
            end
            KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            KIND_READ: begin
              in_range_d = read_ok;
              state_d    = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        pend_value_d = in_range_q ? ram_rdata : '0;
        state_d      = S_DONE;
      end
      S_COPY: begin
        // read cell i + COLUMNS, write it back to cell i in the next cycle
        if (rd_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q != CopyEnd) begin
          rd_valid_d = 1'b1;
          wr_addr_d  = cnt_q;
          cnt_d      = cnt_q + AddrW'(1);
        end else begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        // bottom row
        ram_we = 1'b1;
        if (cnt_q == LastCell) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LastCell) begin
          cursor_d = '0;
          col_d    = '0;
          state_d  = S_DONE;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_cursor_d = cursor_q;
          out_value_d  = pend_value_q;
          out_scroll_d = pend_scroll_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // attribute register, written straight from the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wr_addr_q     <= wr_addr_d;
    in_range_q    <= in_range_d;
    pend_value_q  <= pend_value_d;
    pend_scroll_q <= pend_scroll_d;
    out_cursor_q  <= out_cursor_d;
    out_value_q   <= out_value_d;
    out_scroll_q  <= out_scroll_d;
  end

  tcpc_cell_ram #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cursor_wide       = 32'(out_cursor_q);
  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = cursor_wide[10:0];
  assign cell_value_o      = out_value_q;
  assign scrolled_o        = out_scroll_q;

  // cursor always on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) < CellCount)
    else $error("cursor beyond last cell");

  // column tracker agrees with the cursor
  a_col_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cursor_q) % COLUMNS) == 32'(col_q))
    else $error("column tracker out of step with cursor");

  // copy pipeline only carries data inside a scroll
  a_copy_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == S_COPY))
    else $error("copy write-back outside scroll");

  // after a scroll the cursor sits in the bottom row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scroll_q) |-> (32'(out_cursor_q) >= CopyLen))
    else $error("scrolled result with cursor above bottom row");

endmodule
